// ===== design/quaternion_alu_top_macros.svh =====
// ----------------------------------------------------------------------------
// Quaternion ALU assertion macros
// Shared checking macros; defining NO_ASSERTIONS compiles them away.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_ALU_TOP_MACROS_SVH
`define QUATERNION_ALU_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// condition holds at every clock edge out of reset
`define QALU_CHECK(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("qalu check failed");
// condition in one cycle implies a condition in the next
`define QALU_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("qalu check failed");
`else
`define QALU_CHECK(label, cond)
`define QALU_NEXT(label, pre, post)
`endif
`endif

// ===== design/qalu_pkg.sv =====
// ----------------------------------------------------------------------------
// Quaternion ALU package
// Command codes, queue depth and the control group passed front to back.
// ----------------------------------------------------------------------------
package qalu_pkg;

  localparam int CMD_W      = 4;
  localparam int FIFO_DEPTH = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD   = 4'd0,
    CMD_SUB   = 4'd1,
    CMD_NEG   = 4'd2,
    CMD_CONJ  = 4'd3,
    CMD_MUL   = 4'd4,
    CMD_INV   = 4'd5,
    CMD_ROT   = 4'd6,
    CMD_MAT   = 4'd7,
    CMD_LEN   = 4'd8,
    CMD_LENSQ = 4'd9
  } cmd_t;

  // control that travels with every item
  typedef struct packed {
    cmd_t cmd;
    logic degen;
  } item_ctl_t;

endpackage

// ===== design/qalu_front.sv =====
// ----------------------------------------------------------------------------
// Quaternion ALU front end
// Two stages: all products, then rounded sums, matrix entries and |a|^2.
// ----------------------------------------------------------------------------
module qalu_front import qalu_pkg::*; #(
  parameter int W = 16,
  parameter int F = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  cmd_t             in_cmd,
  input  logic [8*W-1:0]   in_data,
  output logic             out_valid,
  output item_ctl_t        out_ctl,
  output logic [9*W-1:0]   out_words,
  output logic [2*W:0]     out_s
);

  localparam int SW = ((2*W > 2*F+1) ? 2*W : 2*F+1) + 4;
  localparam logic signed [W-1:0]  WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  WMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [SW-1:0] HALF = {{(SW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
  localparam logic signed [SW-1:0] ONE2 = {{(SW-2*F-1){1'b0}}, 1'b1, {(2*F){1'b0}}};

  function automatic logic signed [W-1:0] rndsat(input logic signed [SW-1:0] x);
    logic signed [SW-1:0] t;
    begin
      t = (x + HALF) >>> F;
      if (t > SW'(WMAX))      rndsat = WMAX;
      else if (t < SW'(WMIN)) rndsat = WMIN;
      else                    rndsat = t[W-1:0];
    end
  endfunction

  function automatic logic signed [W-1:0] sat1(input logic signed [W:0] x);
    begin
      if (x > (W+1)'(WMAX))      sat1 = WMAX;
      else if (x < (W+1)'(WMIN)) sat1 = WMIN;
      else                       sat1 = x[W-1:0];
    end
  endfunction

  // operand unpacking; b_w reads as zero for rotation
  logic signed [W-1:0] av [4];
  logic signed [W-1:0] bv [4];
  logic signed [W-1:0] simple [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      av[i] = in_data[i*W +: W];
      bv[i] = in_data[(4+i)*W +: W];
    end
    if (in_cmd == CMD_ROT) bv[0] = '0;
  end

  // add, subtract, negate and conjugate need no product
  always_comb begin
    unique case (in_cmd)
      CMD_ADD: for (int i = 0; i < 4; i++) simple[i] = sat1((W+1)'(av[i]) + (W+1)'(bv[i]));
      CMD_SUB: for (int i = 0; i < 4; i++) simple[i] = sat1((W+1)'(av[i]) - (W+1)'(bv[i]));
      CMD_NEG: for (int i = 0; i < 4; i++) simple[i] = sat1(-(W+1)'(av[i]));
      CMD_CONJ: begin
        simple[0] = av[0];
        for (int i = 1; i < 4; i++) simple[i] = sat1(-(W+1)'(av[i]));
      end
      default: for (int i = 0; i < 4; i++) simple[i] = '0;
    endcase
  end

  // product stage
  logic                  p_valid;
  cmd_t                  p_cmd;
  logic signed [W-1:0]   p_simple [4];
  logic signed [W-1:0]   p_a [4];
  logic signed [2*W-1:0] p_prod [4][4];
  logic signed [2*W-1:0] p_sq [4];
  logic signed [2*W-1:0] p_c12, p_c03, p_c13, p_c02, p_c23, p_c01;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (en) begin
      p_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_cmd <= in_cmd;
      for (int i = 0; i < 4; i++) begin
        p_simple[i] <= simple[i];
        p_a[i]      <= av[i];
        p_sq[i]     <= av[i] * av[i];
        for (int j = 0; j < 4; j++) p_prod[i][j] <= av[i] * bv[j];
      end
      p_c12 <= av[1] * av[2];
      p_c03 <= av[0] * av[3];
      p_c13 <= av[1] * av[3];
      p_c02 <= av[0] * av[2];
      p_c23 <= av[2] * av[3];
      p_c01 <= av[0] * av[1];
    end
  end

  // sums of products, exact, then rounded once
  logic signed [SW-1:0] pe [4][4];
  logic signed [SW-1:0] e12, e03, e13, e02, e23, e01, e1, e2, e3;
  logic signed [W-1:0]  qm [4];
  logic signed [W-1:0]  mm [9];
  logic [2*W:0]         s_sum;
  logic signed [W-1:0]  lensq;
  logic signed [W-1:0]  nw [9];

  always_comb begin
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) pe[i][j] = SW'(p_prod[i][j]);
    qm[0] = rndsat(pe[0][0] - pe[1][1] - pe[2][2] - pe[3][3]);
    qm[1] = rndsat(pe[0][1] + pe[1][0] + pe[2][3] - pe[3][2]);
    qm[2] = rndsat(pe[0][2] - pe[1][3] + pe[2][0] + pe[3][1]);
    qm[3] = rndsat(pe[0][3] + pe[1][2] - pe[2][1] + pe[3][0]);

    e12 = SW'(p_c12) <<< 1;
    e03 = SW'(p_c03) <<< 1;
    e13 = SW'(p_c13) <<< 1;
    e02 = SW'(p_c02) <<< 1;
    e23 = SW'(p_c23) <<< 1;
    e01 = SW'(p_c01) <<< 1;
    e1  = SW'(p_sq[1]) <<< 1;
    e2  = SW'(p_sq[2]) <<< 1;
    e3  = SW'(p_sq[3]) <<< 1;
    mm[0] = rndsat(ONE2 - e2 - e3);
    mm[1] = rndsat(e12 - e03);
    mm[2] = rndsat(e13 + e02);
    mm[3] = rndsat(e12 + e03);
    mm[4] = rndsat(ONE2 - e1 - e3);
    mm[5] = rndsat(e23 - e01);
    mm[6] = rndsat(e13 - e02);
    mm[7] = rndsat(e23 + e01);
    mm[8] = rndsat(ONE2 - e1 - e2);

    s_sum = (2*W+1)'(p_sq[0][2*W-1:0]) + (2*W+1)'(p_sq[1][2*W-1:0])
          + (2*W+1)'(p_sq[2][2*W-1:0]) + (2*W+1)'(p_sq[3][2*W-1:0]);
    lensq = rndsat($signed(SW'(s_sum)));

    // word layout: result or t in 0..3, a in 4..7, matrix rows in 0..8
    unique case (p_cmd)
      CMD_ADD, CMD_SUB, CMD_NEG, CMD_CONJ:
        for (int i = 0; i < 4; i++) nw[i] = p_simple[i];
      CMD_MUL, CMD_ROT:
        for (int i = 0; i < 4; i++) nw[i] = qm[i];
      CMD_MAT:
        for (int i = 0; i < 4; i++) nw[i] = mm[i];
      CMD_LENSQ: begin
        nw[0] = lensq;
        for (int i = 1; i < 4; i++) nw[i] = '0;
      end
      default:
        for (int i = 0; i < 4; i++) nw[i] = '0;
    endcase
    for (int i = 4; i < 8; i++) nw[i] = (p_cmd == CMD_MAT) ? mm[i] : p_a[i-4];
    nw[8] = mm[8];
  end

  // classified item register, feeds the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ctl.cmd   <= p_cmd;
      out_ctl.degen <= (s_sum == '0);
      out_s         <= s_sum;
      for (int i = 0; i < 9; i++) out_words[i*W +: W] <= nw[i];
    end
  end

endmodule

// ===== design/qalu_fifo.sv =====
// ----------------------------------------------------------------------------
// Quaternion ALU item queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`include "quaternion_alu_top_macros.svh"
module qalu_fifo import qalu_pkg::*; #(
  parameter int DW    = 8,
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [DW-1:0] wdata,
  input  logic          pop,
  output logic [DW-1:0] rdata,
  output logic          full,
  output logic          empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [DW-1:0] mem [DEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      if (pop)  rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

  `QALU_CHECK(a_no_overflow, !(push && full))
  `QALU_CHECK(a_no_underflow, !(pop && empty))

endmodule

// ===== design/qalu_div.sv =====
// ----------------------------------------------------------------------------
// Quaternion ALU divider lane
// Pipelined restoring divide: |c| * 2^(2F) / S, rounded, signed, saturated.
// ----------------------------------------------------------------------------
module qalu_div #(
  parameter int W = 16,
  parameter int F = 12
) (
  input  logic                clk,
  input  logic                en,
  input  logic [W-1:0]        mag,
  input  logic                neg,
  input  logic [2*W:0]        s,
  output logic signed [W-1:0] q
);

  localparam int NW  = W + 2*F + 1;
  localparam int DW  = ((NW > 3*W+2) ? NW : 3*W+2) + 1;
  localparam int NST = W + 2;
  localparam logic [W+1:0] LIMP = {3'b000, {(W-1){1'b1}}};
  localparam logic [W+1:0] LIMN = {3'b001, {(W-1){1'b0}}};

  logic [DW-1:0] rem [NST];
  logic [W:0]    qv  [NST];
  logic [2*W:0]  sv  [NST];
  logic          ng  [NST];
  logic          ov  [NST];
  logic [DW-1:0] n_in;

  // twice the dividend, so the last quotient bit is the rounding bit
  assign n_in = DW'(mag) << (2*F + 1);

  // entry: overflow when the doubled quotient needs more than W+1 bits
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= n_in;
      qv[0]  <= '0;
      sv[0]  <= s;
      ng[0]  <= neg;
      ov[0]  <= (n_in >= (DW'(s) << (W + 1)));
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar k = 1; k < NST; k++) begin : g_step
    localparam int BI = W + 1 - k;
    logic [DW-1:0] dv;
    logic          fit;
    assign dv  = DW'(sv[k-1]) << BI;
    assign fit = (rem[k-1] >= dv);
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= fit ? rem[k-1] - dv : rem[k-1];
        qv[k]  <= qv[k-1] | ((W+1)'(fit) << BI);
        sv[k]  <= sv[k-1];
        ng[k]  <= ng[k-1];
        ov[k]  <= ov[k-1];
      end
    end
  end

  // round half up on magnitude, apply sign, saturate
  logic [W+1:0] qr, qneg;
  assign qr   = ({1'b0, qv[NST-1]} + (W+2)'(1)) >> 1;
  assign qneg = ~qr + 1'b1;

  always_ff @(posedge clk) begin
    if (en) begin
      if (ng[NST-1]) begin
        q <= (ov[NST-1] || qr > LIMN) ? {1'b1, {(W-1){1'b0}}} : qneg[W-1:0];
      end else begin
        q <= (ov[NST-1] || qr > LIMP) ? {1'b0, {(W-1){1'b1}}} : qr[W-1:0];
      end
    end
  end

endmodule

// ===== design/qalu_sqrt.sv =====
// ----------------------------------------------------------------------------
// Quaternion ALU square root
// Pipelined digit-by-digit root of S, rounded to nearest, saturated.
// ----------------------------------------------------------------------------
module qalu_sqrt #(
  parameter int W = 16
) (
  input  logic                clk,
  input  logic                en,
  input  logic [2*W:0]        s,
  output logic signed [W-1:0] root
);

  localparam int SQW = 2*W + 3;
  localparam int NST = W + 2;
  localparam logic [W+1:0] LIMP = {3'b000, {(W-1){1'b1}}};

  logic [SQW-1:0] n [NST];
  logic [W:0]     r [NST];

  always_ff @(posedge clk) begin
    if (en) begin
      n[0] <= SQW'(s);
      r[0] <= '0;
    end
  end

  // one root bit per stage: accept when (r + 2^i)^2 - r^2 fits the remainder
  for (genvar k = 1; k < NST; k++) begin : g_step
    localparam int BI = W + 1 - k;
    logic [SQW-1:0] trial;
    logic           fit;
    assign trial = (SQW'(r[k-1]) << (BI + 1)) + (SQW'(1) << (2*BI));
    assign fit   = (n[k-1] >= trial);
    always_ff @(posedge clk) begin
      if (en) begin
        n[k] <= fit ? n[k-1] - trial : n[k-1];
        r[k] <= r[k-1] | ((W+1)'(fit) << BI);
      end
    end
  end

  // round up when the remainder exceeds the root
  logic [W+1:0] res;
  assign res = {1'b0, r[NST-1]} + (W+2)'(n[NST-1] > SQW'(r[NST-1]));

  always_ff @(posedge clk) begin
    if (en) begin
      root <= (res > LIMP) ? {1'b0, {(W-1){1'b1}}} : res[W-1:0];
    end
  end

endmodule

// ===== design/qalu_back.sv =====
// ----------------------------------------------------------------------------
// Quaternion ALU back end
// Divider and root lanes, rotation product, result select, row output.
// ----------------------------------------------------------------------------
`include "quaternion_alu_top_macros.svh"
module qalu_back import qalu_pkg::*; #(
  parameter int W = 16,
  parameter int F = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  item_ctl_t           in_ctl,
  input  logic [9*W-1:0]      in_words,
  input  logic [2*W:0]        in_s,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [W-1:0] res_w,
  output logic signed [W-1:0] res_x,
  output logic signed [W-1:0] res_y,
  output logic signed [W-1:0] res_z,
  output logic                degenerate,
  output logic                last
);

  localparam int L  = W + 3;
  localparam int SW = ((2*W > 2*F+1) ? 2*W : 2*F+1) + 4;
  localparam logic signed [W-1:0]  WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  WMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [SW-1:0] HALF = {{(SW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
  localparam logic signed [W-1:0]  ONE_SAT = (F > W - 2) ? WMAX : (W'(1) << F);

  function automatic logic signed [W-1:0] rndsat(input logic signed [SW-1:0] x);
    logic signed [SW-1:0] t;
    begin
      t = (x + HALF) >>> F;
      if (t > SW'(WMAX))      rndsat = WMAX;
      else if (t < SW'(WMIN)) rndsat = WMIN;
      else                    rndsat = t[W-1:0];
    end
  endfunction

  logic en;
  logic ob_valid, ob_mat, ob_dg, ob_last;
  logic [1:0] ob_row;
  cmd_t ob_cmd;
  logic signed [W-1:0] ob_words [9];

  // whole back end advances unless the output still holds rows
  assign en       = !ob_valid || (out_ready && ob_last);
  assign in_ready = en;

  // inverse lanes take conj(a): w keeps its sign, x..z flip
  logic signed [W-1:0] a_in [4];
  logic [W-1:0]        mag [4];
  logic                neg [4];
  logic signed [W-1:0] inv [4];
  logic signed [W-1:0] len;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      a_in[i] = in_words[(4+i)*W +: W];
      mag[i]  = a_in[i][W-1] ? (~a_in[i] + 1'b1) : a_in[i];
    end
    neg[0] = a_in[0][W-1];
    for (int i = 1; i < 4; i++) neg[i] = !a_in[i][W-1] && (a_in[i] != '0);
  end

  for (genvar i = 0; i < 4; i++) begin : g_div
    qalu_div #(.W(W), .F(F)) u_div (
      .clk (clk),
      .en  (en),
      .mag (mag[i]),
      .neg (neg[i]),
      .s   (in_s),
      .q   (inv[i])
    );
  end

  qalu_sqrt #(.W(W)) u_sqrt (
    .clk  (clk),
    .en   (en),
    .s    (in_s),
    .root (len)
  );

  // side line matching the divider latency
  logic [L-1:0]   sd_valid;
  item_ctl_t      sd_ctl [L];
  logic [9*W-1:0] sd_words [L];

  always_ff @(posedge clk) begin
    if (rst) begin
      sd_valid <= '0;
    end else if (en) begin
      sd_valid <= {sd_valid[L-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_ctl[0]   <= in_ctl;
      sd_words[0] <= in_words;
      for (int k = 1; k < L; k++) begin
        sd_ctl[k]   <= sd_ctl[k-1];
        sd_words[k] <= sd_words[k-1];
      end
    end
  end

  // rotation products t * inverse
  logic                  r1_valid;
  item_ctl_t             r1_ctl;
  logic signed [W-1:0]   r1_words [9];
  logic signed [W-1:0]   r1_inv [4];
  logic signed [W-1:0]   r1_len;
  logic signed [2*W-1:0] r1_p [4][4];
  logic signed [W-1:0]   tv [4];

  always_comb begin
    for (int i = 0; i < 4; i++) tv[i] = sd_words[L-1][i*W +: W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_valid <= 1'b0;
    end else if (en) begin
      r1_valid <= sd_valid[L-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_ctl <= sd_ctl[L-1];
      r1_len <= len;
      for (int i = 0; i < 9; i++) r1_words[i] <= sd_words[L-1][i*W +: W];
      for (int i = 0; i < 4; i++) begin
        r1_inv[i] <= inv[i];
        for (int j = 0; j < 4; j++) r1_p[i][j] <= tv[i] * inv[j];
      end
    end
  end

  // rotated vector and final result select
  logic signed [SW-1:0] pe [4][4];
  logic signed [W-1:0]  rv [4];
  logic signed [W-1:0]  nw [9];
  logic                 ndg, nmat;

  always_comb begin
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) pe[i][j] = SW'(r1_p[i][j]);
    rv[0] = '0;
    rv[1] = rndsat(pe[0][1] + pe[1][0] + pe[2][3] - pe[3][2]);
    rv[2] = rndsat(pe[0][2] - pe[1][3] + pe[2][0] + pe[3][1]);
    rv[3] = rndsat(pe[0][3] + pe[1][2] - pe[2][1] + pe[3][0]);

    for (int i = 0; i < 9; i++) nw[i] = r1_words[i];
    ndg  = 1'b0;
    nmat = 1'b0;
    unique case (r1_ctl.cmd)
      CMD_INV: begin
        ndg = r1_ctl.degen;
        for (int i = 0; i < 4; i++) nw[i] = r1_ctl.degen ? '0 : r1_inv[i];
        if (r1_ctl.degen) nw[0] = ONE_SAT;
      end
      CMD_ROT: begin
        ndg = r1_ctl.degen;
        for (int i = 0; i < 4; i++) nw[i] = r1_ctl.degen ? '0 : rv[i];
      end
      CMD_LEN: begin
        nw[0] = r1_len;
        for (int i = 1; i < 4; i++) nw[i] = '0;
      end
      CMD_MAT: nmat = 1'b1;
      default: ;
    endcase
  end

  // output register; a matrix leaves as three rows
  assign ob_last = !ob_mat || (ob_row == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_valid <= 1'b0;
      ob_row   <= '0;
    end else if (en) begin
      ob_valid <= r1_valid;
      ob_row   <= '0;
    end else if (out_ready) begin
      ob_row <= ob_row + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ob_mat <= nmat;
      ob_dg  <= ndg;
      ob_cmd <= r1_ctl.cmd;
      for (int i = 0; i < 9; i++) ob_words[i] <= nw[i];
    end
  end

  always_comb begin
    if (ob_mat) begin
      res_w = '0;
      unique case (ob_row)
        2'd1: begin
          res_x = ob_words[3]; res_y = ob_words[4]; res_z = ob_words[5];
        end
        2'd2: begin
          res_x = ob_words[6]; res_y = ob_words[7]; res_z = ob_words[8];
        end
        default: begin
          res_x = ob_words[0]; res_y = ob_words[1]; res_z = ob_words[2];
        end
      endcase
    end else begin
      res_w = ob_words[0];
      res_x = ob_words[1];
      res_y = ob_words[2];
      res_z = ob_words[3];
    end
  end

  assign out_valid  = ob_valid;
  assign degenerate = ob_dg;
  assign last       = ob_last;

  `QALU_CHECK(a_row_only_matrix, ob_mat || (ob_row == 2'd0))
  `QALU_CHECK(a_dg_cmd, !(ob_valid && ob_dg) || (ob_cmd == CMD_INV) || (ob_cmd == CMD_ROT))
  `QALU_NEXT(a_row_step, ob_valid && !ob_last && out_ready, ob_row == $past(ob_row) + 2'd1)

endmodule

// ===== design/quaternion_alu_top.sv =====
// ----------------------------------------------------------------------------
// Quaternion ALU top level
// Fixed-point quaternion unit: front end, item queue, back end.
//
//   channel  dir  tdata                     tuser        tlast
//   s_*      in   a_w a_x a_y a_z b_w..b_z  cmd          -
//   m_*      out  res_w res_x res_y res_z   degenerate   last
//
// One item is taken per cycle while s_tready is high; results pass the front
// end, the queue and the back end's one-bit-per-stage divider and root lanes.
// A matrix item holds the output register until its three rows are taken.
// The front end stalls only when the four-entry queue is full; the back end
// stalls as a whole while the output register waits for m_tready.
// Synchronous reset clears all valid flags; there is no clearing pass.
// ----------------------------------------------------------------------------
module quaternion_alu_top import qalu_pkg::*; #(
  parameter int WORD_BITS = 16,
  parameter int FRAC_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z from bit 0 up
  input  logic [8*WORD_BITS-1:0] s_tdata,
  // cmd
  input  logic [CMD_W-1:0]       s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // res_w, res_x, res_y, res_z from bit 0 up, zero padded to bytes
  output logic [((4*WORD_BITS+7)/8)*8-1:0] m_tdata,
  // degenerate
  output logic                   m_tuser,
  output logic                   m_tlast
);

  localparam int W   = WORD_BITS;
  localparam int OTD = ((4*W + 7) / 8) * 8;
  localparam int QDW = $bits(item_ctl_t) + 9*W + 2*W + 1;

  logic            f_en, f_valid;
  item_ctl_t       f_ctl;
  logic [9*W-1:0]  f_words;
  logic [2*W:0]    f_s;
  logic            q_full, q_empty, q_push, q_pop, b_ready;
  logic [QDW-1:0]  q_rdata;
  item_ctl_t       b_ctl;
  logic [9*W-1:0]  b_words;
  logic [2*W:0]    b_s;
  logic signed [W-1:0] res_w, res_x, res_y, res_z;

  // front advances unless its finished item cannot enter the queue
  assign f_en     = !(f_valid && q_full);
  assign s_tready = f_en;
  assign q_push   = f_valid && !q_full;
  assign q_pop    = b_ready && !q_empty;

  qalu_front #(.W(W), .F(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (f_en),
    .in_valid  (s_tvalid),
    .in_cmd    (cmd_t'(s_tuser)),
    .in_data   (s_tdata),
    .out_valid (f_valid),
    .out_ctl   (f_ctl),
    .out_words (f_words),
    .out_s     (f_s)
  );

  qalu_fifo #(.DW(QDW), .DEPTH(FIFO_DEPTH)) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata ({f_ctl, f_words, f_s}),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  assign {b_ctl, b_words, b_s} = q_rdata;

  qalu_back #(.W(W), .F(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (!q_empty),
    .in_ready   (b_ready),
    .in_ctl     (b_ctl),
    .in_words   (b_words),
    .in_s       (b_s),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .res_w      (res_w),
    .res_x      (res_x),
    .res_y      (res_y),
    .res_z      (res_z),
    .degenerate (m_tuser),
    .last       (m_tlast)
  );

  assign m_tdata = OTD'({res_z, res_y, res_x, res_w});

endmodule

// ===== sim/quaternion_alu_top_tb.sv =====
// ----------------------------------------------------------------------------
// Quaternion ALU testbench
// Streams directed and random quaternion commands into the unit, predicts
// every result word in Q3.12 fixed point and checks the output stream in
// order, with random idle bursts and one long output hold-off.
// ----------------------------------------------------------------------------
module quaternion_alu_top_tb;
  import qalu_pkg::*;

  localparam int  WB       = 16;
  localparam int  FB       = 12;
  localparam longint ONE_Q = 64'sd1 <<< FB;
  localparam longint WMAX  = (64'sd1 <<< (WB - 1)) - 1;
  localparam longint WMIN  = -(64'sd1 <<< (WB - 1));
  localparam longint QBIG  = 64'sd1 <<< 40;
  localparam int  N_RAND   = 450;
  localparam int  QUIET_AT = 60;
  localparam int  HOLD_LEN = 400;
  localparam int  WD_LIMIT = 5000;
  localparam int  DRAIN    = 60;

  typedef struct packed {
    cmd_t              cmd;
    logic [3:0][WB-1:0] a;
    logic [3:0][WB-1:0] b;
  } qop_t;

  typedef struct packed {
    logic [WB-1:0] w, x, y, z;
    logic          degen;
    logic          last;
  } qres_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [8*WB-1:0]   s_tdata = '0;
  logic [CMD_W-1:0]  s_tuser = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [4*WB-1:0]   m_tdata;
  logic              m_tuser;
  logic              m_tlast;

  qop_t   pending_ops[$];
  qres_t  expected_res[$];
  int     errors = 0;
  int     in_idle = 0;
  int     out_stall = 0;
  int     hold_cnt = 0;
  bit     hold_done = 1'b0;
  int     results_seen = 0;
  int     idle_cycles = 0;

  quaternion_alu_top #(.WORD_BITS(WB), .FRAC_BITS(FB)) u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------- fixed-point predictor ----------------
  function automatic longint sat_w(input longint v);
    if (v > WMAX) return WMAX;
    if (v < WMIN) return WMIN;
    return v;
  endfunction

  function automatic longint floor_div(input longint n, input longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  // exact sum of four weighted products, rounded half up, saturated
  function automatic longint dot_round(input longint x[4], input longint y[4],
                                       input longint k[4], input longint base);
    longint q, r, p;
    q = base;
    r = 0;
    for (int i = 0; i < 4; i++) begin
      p = x[i] * y[i];
      q = q + (p / ONE_Q) * k[i];
      r = r + (p % ONE_Q) * k[i];
    end
    return sat_w(q + floor_div(r + ONE_Q / 2, ONE_Q));
  endfunction

  function automatic void hamilton(input longint p[4], input longint s[4],
                                   output longint o[4]);
    o[0] = dot_round('{p[0], p[1], p[2], p[3]}, '{s[0], s[1], s[2], s[3]},
                     '{1, -1, -1, -1}, 0);
    o[1] = dot_round('{p[0], p[1], p[2], p[3]}, '{s[1], s[0], s[3], s[2]},
                     '{1, 1, 1, -1}, 0);
    o[2] = dot_round('{p[0], p[1], p[2], p[3]}, '{s[2], s[3], s[0], s[1]},
                     '{1, -1, 1, 1}, 0);
    o[3] = dot_round('{p[0], p[1], p[2], p[3]}, '{s[3], s[2], s[1], s[0]},
                     '{1, 1, -1, 1}, 0);
  endfunction

  // one matrix entry: optional one plus two doubled products
  function automatic longint mat_entry(input bit one, input longint x1, input longint y1,
                                       input longint k1, input longint x2,
                                       input longint y2, input longint k2);
    return dot_round('{x1, x2, 0, 0}, '{y1, y2, 0, 0}, '{k1, k2, 0, 0},
                     one ? ONE_Q : 0);
  endfunction

  // conj component divided by squared length, rounded half away from zero
  function automatic longint recip_div(input longint c, input longint s);
    longint m, qq, r;
    m  = (c < 0) ? -c : c;
    qq = m / s;
    r  = m % s;
    for (int i = 0; i < 2 * FB && qq <= QBIG; i++) begin
      qq = qq << 1;
      if (r >= s - r) begin
        r  = r - (s - r);
        qq = qq | 1;
      end else begin
        r = r << 1;
      end
    end
    if (qq <= QBIG && r >= s - r) qq = qq + 1;
    if (qq > QBIG) qq = QBIG;
    return sat_w((c < 0) ? -qq : qq);
  endfunction

  function automatic bit q_inverse(input longint a[4], output longint o[4]);
    longint s;
    s = a[0] * a[0] + a[1] * a[1] + a[2] * a[2] + a[3] * a[3];
    if (s == 0) begin
      o = '{sat_w(ONE_Q), 0, 0, 0};
      return 1'b1;
    end
    o[0] = recip_div(a[0], s);
    for (int i = 1; i < 4; i++) o[i] = recip_div(-a[i], s);
    return 1'b0;
  endfunction

  function automatic longint q_length(input longint a[4]);
    longint s, root, cand;
    s = a[0] * a[0] + a[1] * a[1] + a[2] * a[2] + a[3] * a[3];
    root = 0;
    for (int bt = 17; bt >= 0; bt--) begin
      cand = root | (64'sd1 <<< bt);
      if (cand * cand <= s) root = cand;
    end
    if (s - root * root > root) root = root + 1;
    return sat_w(root);
  endfunction

  function automatic void push_res(input longint w, input longint x, input longint y,
                                   input longint z, input bit dg, input bit lst);
    qres_t e;
    e.w = w[WB-1:0];
    e.x = x[WB-1:0];
    e.y = y[WB-1:0];
    e.z = z[WB-1:0];
    e.degen = dg;
    e.last  = lst;
    expected_res.push_back(e);
  endfunction

  function automatic void predict_results(input qop_t op);
    longint a[4], b[4], r[4], t[4], inv[4];
    bit dg;
    for (int i = 0; i < 4; i++) begin
      a[i] = longint'($signed(op.a[i]));
      b[i] = longint'($signed(op.b[i]));
    end
    case (op.cmd)
      CMD_ADD: begin
        for (int i = 0; i < 4; i++) r[i] = sat_w(a[i] + b[i]);
        push_res(r[0], r[1], r[2], r[3], 0, 1);
      end
      CMD_SUB: begin
        for (int i = 0; i < 4; i++) r[i] = sat_w(a[i] - b[i]);
        push_res(r[0], r[1], r[2], r[3], 0, 1);
      end
      CMD_NEG: push_res(sat_w(-a[0]), sat_w(-a[1]), sat_w(-a[2]), sat_w(-a[3]), 0, 1);
      CMD_CONJ: push_res(a[0], sat_w(-a[1]), sat_w(-a[2]), sat_w(-a[3]), 0, 1);
      CMD_MUL: begin
        hamilton(a, b, r);
        push_res(r[0], r[1], r[2], r[3], 0, 1);
      end
      CMD_INV: begin
        dg = q_inverse(a, r);
        push_res(r[0], r[1], r[2], r[3], dg, 1);
      end
      CMD_ROT: begin
        dg = q_inverse(a, inv);
        if (dg) begin
          push_res(0, 0, 0, 0, 1, 1);
        end else begin
          b[0] = 0;
          hamilton(a, b, t);
          hamilton(t, inv, r);
          push_res(0, r[1], r[2], r[3], 0, 1);
        end
      end
      CMD_MAT: begin
        push_res(0, mat_entry(1, a[2], a[2], -2, a[3], a[3], -2),
                 mat_entry(0, a[1], a[2], 2, a[0], a[3], -2),
                 mat_entry(0, a[1], a[3], 2, a[0], a[2], 2), 0, 0);
        push_res(0, mat_entry(0, a[1], a[2], 2, a[0], a[3], 2),
                 mat_entry(1, a[1], a[1], -2, a[3], a[3], -2),
                 mat_entry(0, a[2], a[3], 2, a[0], a[1], -2), 0, 0);
        push_res(0, mat_entry(0, a[1], a[3], 2, a[0], a[2], -2),
                 mat_entry(0, a[2], a[3], 2, a[0], a[1], 2),
                 mat_entry(1, a[1], a[1], -2, a[2], a[2], -2), 0, 1);
      end
      CMD_LEN: push_res(q_length(a), 0, 0, 0, 0, 1);
      CMD_LENSQ: push_res(dot_round(a, a, '{1, 1, 1, 1}, 0), 0, 0, 0, 0, 1);
      default: push_res(0, 0, 0, 0, 0, 1);
    endcase
  endfunction

  // ---------------- stimulus ----------------
  function automatic logic [WB-1:0] rand_word();
    case ($urandom_range(0, 5))
      0, 1: return WB'($urandom);
      2: return WB'($urandom_range(0, 8192) - 4096);
      3: return WB'($urandom_range(0, 16) - 8);
      4: return ($urandom_range(0, 1) != 0) ? WB'(WMAX) : WB'(WMIN);
      default: return WB'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  function automatic void add_op(input cmd_t c, input longint a0, input longint a1,
                                 input longint a2, input longint a3, input longint b0,
                                 input longint b1, input longint b2, input longint b3);
    qop_t op;
    op.cmd = c;
    op.a = {WB'(a3), WB'(a2), WB'(a1), WB'(a0)};
    op.b = {WB'(b3), WB'(b2), WB'(b1), WB'(b0)};
    pending_ops.push_back(op);
  endfunction

  // ---------------- driver ----------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        predict_results(pending_ops[0]);
        void'(pending_ops.pop_front());
      end
      if (in_idle > 0) begin
        in_idle  <= in_idle - 1;
        s_tvalid <= 1'b0;
      end else if (pending_ops.size() > QUIET_AT && $urandom_range(0, 5) == 0) begin
        in_idle  <= $urandom_range(0, 16);
        s_tvalid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        s_tvalid <= 1'b1;
        s_tdata  <= {pending_ops[0].b, pending_ops[0].a};
        s_tuser  <= pending_ops[0].cmd;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // ---------------- monitor and checker ----------------
  always @(posedge clk) begin
    qres_t got, exp_r;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = {m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tdata[63:48],
               m_tuser, m_tlast};
        results_seen <= results_seen + 1;
        if (expected_res.size() == 0) begin
          $error("result transfer with nothing expected: %h", got);
          errors = errors + 1;
        end else begin
          exp_r = expected_res.pop_front();
          if (got.w !== exp_r.w) begin
            $error("res_w expected %h actual %h", exp_r.w, got.w); errors = errors + 1;
          end
          if (got.x !== exp_r.x) begin
            $error("res_x expected %h actual %h", exp_r.x, got.x); errors = errors + 1;
          end
          if (got.y !== exp_r.y) begin
            $error("res_y expected %h actual %h", exp_r.y, got.y); errors = errors + 1;
          end
          if (got.z !== exp_r.z) begin
            $error("res_z expected %h actual %h", exp_r.z, got.z); errors = errors + 1;
          end
          if (got.degen !== exp_r.degen) begin
            $error("degenerate expected %b actual %b", exp_r.degen, got.degen);
            errors = errors + 1;
          end
          if (got.last !== exp_r.last) begin
            $error("last expected %b actual %b", exp_r.last, got.last);
            errors = errors + 1;
          end
        end
      end
      // long hold-off once, so the queue fills and the input stalls
      if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        m_tready <= 1'b0;
      end else if (!hold_done && results_seen >= 80) begin
        hold_done <= 1'b1;
        hold_cnt  <= HOLD_LEN;
        m_tready  <= 1'b0;
      end else if (out_stall > 0) begin
        out_stall <= out_stall - 1;
        m_tready  <= 1'b0;
      end else if (pending_ops.size() > QUIET_AT && $urandom_range(0, 5) == 0) begin
        out_stall <= $urandom_range(0, 16);
        m_tready  <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
        $display("FAIL quaternion_alu_top");
        $finish;
      end
    end
  end

  // ---------------- sequence ----------------
  initial begin
    cmd_t c;
    // directed: extremes, every command, zero length and saturation cases
    add_op(CMD_ADD, WMAX, WMIN, WMAX, 1, WMAX, WMIN, WMIN, -1);
    add_op(CMD_SUB, WMIN, WMAX, 0, 100, WMAX, WMIN, 0, -100);
    add_op(CMD_NEG, WMIN, WMAX, 0, -1, 0, 0, 0, 0);
    add_op(CMD_CONJ, WMIN, WMIN, WMAX, 0, 0, 0, 0, 0);
    add_op(CMD_MUL, ONE_Q, 0, 0, 0, 1234, -567, 89, -4321);
    add_op(CMD_MUL, WMIN, WMIN, WMIN, WMIN, WMIN, WMAX, WMIN, WMAX);
    add_op(CMD_MUL, 2048, -2048, 2048, -2048, 1, 1, -1, 1);
    add_op(CMD_INV, 0, 0, 0, 0, 0, 0, 0, 0);
    add_op(CMD_INV, ONE_Q, 0, 0, 0, 0, 0, 0, 0);
    add_op(CMD_INV, 1, 0, 0, -1, 0, 0, 0, 0);
    add_op(CMD_INV, WMIN, WMIN, WMIN, WMIN, 0, 0, 0, 0);
    add_op(CMD_ROT, 0, 0, 0, 0, 5, 6, 7, 8);
    add_op(CMD_ROT, ONE_Q, 0, 0, 0, 0, 1000, -2000, 3000);
    add_op(CMD_ROT, 2896, 0, 0, 2896, WMAX, ONE_Q, 0, 0);
    add_op(CMD_ROT, 1, 1, 0, 0, 0, WMAX, WMIN, WMAX);
    add_op(CMD_MAT, ONE_Q, 0, 0, 0, 0, 0, 0, 0);
    add_op(CMD_MAT, WMIN, WMAX, WMIN, WMAX, 0, 0, 0, 0);
    add_op(CMD_MAT, 2048, 2048, 2048, 2048, 0, 0, 0, 0);
    add_op(CMD_LEN, WMIN, WMIN, WMIN, WMIN, 0, 0, 0, 0);
    add_op(CMD_LEN, 0, 0, 0, 0, 0, 0, 0, 0);
    add_op(CMD_LEN, 3, 4, 0, 0, 0, 0, 0, 0);
    add_op(CMD_LENSQ, WMAX, WMAX, WMAX, WMAX, 0, 0, 0, 0);
    add_op(CMD_LENSQ, ONE_Q, 0, 0, 0, 0, 0, 0, 0);
    add_op(CMD_LENSQ, 1, -1, 63, -64, 0, 0, 0, 0);
    // random commands with mixed operand ranges
    for (int n = 0; n < N_RAND; n++) begin
      c = cmd_t'($urandom_range(0, 9));
      add_op(c, $signed(rand_word()), $signed(rand_word()), $signed(rand_word()),
             $signed(rand_word()), $signed(rand_word()), $signed(rand_word()),
             $signed(rand_word()), $signed(rand_word()));
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    wait (pending_ops.size() == 0 && expected_res.size() == 0);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0 && expected_res.size() == 0) begin
      $display("PASS quaternion_alu_top");
    end else begin
      $display("FAIL quaternion_alu_top");
    end
    $finish;
  end

endmodule
